// ----- design/b64d_pkg.sv -----
// Shared types, constants and decode functions for the base64 stream decoder.
package b64d_pkg;

  localparam int CharW = 8;
  localparam int ByteW = 8;
  localparam int SymW  = 7;
  localparam int BitsW = 6;
  localparam int AccW  = 24;
  localparam int PadW  = 3;
  localparam int HeldW = 2;
  localparam int CntW  = 2;

  localparam int QueueDepthDef = 4;

  localparam logic [SymW-1:0] SymPad  = 7'd64;
  localparam logic [SymW-1:0] SymSkip = 7'd65;
  localparam logic [SymW-1:0] SymPlus = 7'd62;
  localparam logic [SymW-1:0] SymSlash = 7'd63;

  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] ChLoA   = 8'h61;
  localparam logic [CharW-1:0] ChLoZ   = 8'h7A;
  localparam logic [CharW-1:0] ChDig0  = 8'h30;
  localparam logic [CharW-1:0] ChDig9  = 8'h39;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;
  localparam logic [CharW-1:0] ChUnder = 8'h5F;
  localparam logic [CharW-1:0] ChEq    = 8'h3D;

  localparam logic [CharW-1:0] LowerBase = 8'd26;
  localparam logic [CharW-1:0] DigitBase = 8'd52;

  localparam logic [PadW-1:0] PadsNoBytes = 3'd3;

  typedef struct packed {
    logic [AccW-1:0] bits;
    logic [CntW-1:0] nbytes;
    logic            done;
  } b64d_grp_t;

  function automatic logic [SymW-1:0] sym_decode(input logic [CharW-1:0] ch);
    logic [SymW-1:0] s;
    s = SymSkip;
    if (ch >= ChUpA && ch <= ChUpZ) begin
      s = SymW'(ch - ChUpA);
    end else if (ch >= ChLoA && ch <= ChLoZ) begin
      s = SymW'(ch - ChLoA + LowerBase);
    end else if (ch >= ChDig0 && ch <= ChDig9) begin
      s = SymW'(ch - ChDig0 + DigitBase);
    end else if (ch == ChPlus || ch == ChMinus) begin
      s = SymPlus;
    end else if (ch == ChSlash || ch == ChUnder) begin
      s = SymSlash;
    end else if (ch == ChEq) begin
      s = SymPad;
    end
    return s;
  endfunction

  function automatic logic [CntW-1:0] bytes_for_pads(input logic [PadW-1:0] pads);
    logic [CntW-1:0] n;
    if (pads >= PadsNoBytes) begin
      n = '0;
    end else begin
      n = CntW'(PadsNoBytes - pads);
    end
    return n;
  endfunction

endpackage

// ----- design/b64d_chan_if.sv -----
// Valid/ready channel interfaces for text characters and decoded bytes.
interface b64d_in_if;
  import b64d_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_out_if;
  import b64d_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             last_in_run;
  logic             text_done;

  modport source (output valid, output out_byte, output last_in_run, output text_done,
                  input ready);
  modport sink   (input valid, input out_byte, input last_in_run, input text_done,
                  output ready);
endinterface

// ----- design/b64d_front.sv -----
// Front end: classifies characters, gathers quartets and forms byte groups.
module b64d_front (
  input  logic                 clk,
  input  logic                 rst_n,
  b64d_in_if.sink              in_chan,
  input  logic                 q_full,
  output logic                 push,
  output b64d_pkg::b64d_grp_t  push_grp
);
  import b64d_pkg::*;

  logic [AccW-1:0]  acc_r, acc_nxt;
  logic [HeldW-1:0] held_r, held_nxt;
  logic [PadW-1:0]  pads_r, pads_nxt;

  logic [SymW-1:0]  sym;
  logic             is_skip;
  logic             is_pad;
  logic [BitsW-1:0] bits6;
  logic [AccW-1:0]  acc_shift;
  logic [PadW-1:0]  pads_inc;
  logic [AccW-1:0]  acc_a;
  logic [HeldW-1:0] held_a;
  logic [PadW-1:0]  pads_a;
  logic [PadW-1:0]  pads_f;
  logic [AccW-1:0]  grp_bits;
  logic [CntW-1:0]  grp_n;
  logic             accept;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;

  always_comb begin
    sym       = sym_decode(in_chan.char_code);
    is_skip   = (sym == SymSkip);
    is_pad    = (sym == SymPad);
    bits6     = is_pad ? '0 : sym[BitsW-1:0];
    acc_shift = {acc_r[AccW-BitsW-1:0], bits6};
    pads_inc  = pads_r + PadW'(is_pad);

    acc_a    = acc_r;
    held_a   = held_r;
    pads_a   = pads_r;
    grp_bits = '0;
    grp_n    = '0;
    pads_f   = '0;

    if (!is_skip) begin
      if (held_r == HeldW'(3)) begin
        grp_bits = acc_shift;
        grp_n    = bytes_for_pads(pads_inc);
        acc_a    = '0;
        held_a   = '0;
        pads_a   = '0;
      end else begin
        acc_a  = acc_shift;
        held_a = held_r + HeldW'(1);
        pads_a = pads_inc;
      end
    end

    // pad a partial quartet out to four symbols on end of text
    if (in_chan.end_of_text && held_a != '0) begin
      unique case (held_a)
        HeldW'(1): begin
          grp_bits = {acc_a[BitsW-1:0], {(AccW-BitsW){1'b0}}};
          pads_f   = pads_a + PadW'(3);
        end
        HeldW'(2): begin
          grp_bits = {acc_a[2*BitsW-1:0], {(AccW-2*BitsW){1'b0}}};
          pads_f   = pads_a + PadW'(2);
        end
        default: begin
          grp_bits = {acc_a[3*BitsW-1:0], {(AccW-3*BitsW){1'b0}}};
          pads_f   = pads_a + PadW'(1);
        end
      endcase
      grp_n = bytes_for_pads(pads_f);
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    held_nxt = held_r;
    pads_nxt = pads_r;
    if (accept) begin
      if (in_chan.end_of_text) begin
        acc_nxt  = '0;
        held_nxt = '0;
        pads_nxt = '0;
      end else begin
        acc_nxt  = acc_a;
        held_nxt = held_a;
        pads_nxt = pads_a;
      end
    end
  end

  assign push            = accept && (grp_n != '0);
  assign push_grp.bits   = grp_bits;
  assign push_grp.nbytes = grp_n;
  assign push_grp.done   = in_chan.end_of_text;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
      pads_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
      pads_r <= pads_nxt;
    end
  end

endmodule

// ----- design/b64d_queue.sv -----
// Short group queue between the front end and the byte serializer.
module b64d_queue #(
  parameter int Depth = b64d_pkg::QueueDepthDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  b64d_pkg::b64d_grp_t  push_grp,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output b64d_pkg::b64d_grp_t  head_grp
);
  import b64d_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntQW = $clog2(Depth + 1);

  b64d_grp_t        mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntQW-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (cnt_r == CntQW'(Depth));
  assign head_valid = (cnt_r != '0);
  assign head_grp   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntQW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntQW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- design/b64d_back.sv -----
// Back end: serializes each group into bytes through an output register.
module b64d_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  b64d_pkg::b64d_grp_t  head_grp,
  output logic                 pop,
  b64d_out_if.source           out_chan
);
  import b64d_pkg::*;

  logic [CntW-1:0]  idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [ByteW-1:0] byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic             done_r, done_nxt;
  logic             take;
  logic             is_last;
  logic [ByteW-1:0] sel_byte;

  assign take    = !valid_r || out_chan.ready;
  assign is_last = (idx_r == head_grp.nbytes - CntW'(1));

  always_comb begin
    unique case (idx_r)
      CntW'(0): sel_byte = head_grp.bits[AccW-1 -: ByteW];
      CntW'(1): sel_byte = head_grp.bits[AccW-ByteW-1 -: ByteW];
      default:  sel_byte = head_grp.bits[ByteW-1:0];
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    done_nxt  = done_r;
    pop       = 1'b0;
    if (take) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        byte_nxt = sel_byte;
        last_nxt = is_last;
        done_nxt = is_last && head_grp.done;
        if (is_last) begin
          idx_nxt = '0;
          pop     = 1'b1;
        end else begin
          idx_nxt = idx_r + CntW'(1);
        end
      end
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.out_byte    = byte_r;
  assign out_chan.last_in_run = last_r;
  assign out_chan.text_done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

endmodule

// ----- design/base64_stream_decoder_core.sv -----
// Top level of the base64 stream decoder: front end, group queue and byte serializer.
//
//   channel   dir  request payload
//   in_chan   in   char_code[7:0], end_of_text
//   out_chan  out  out_byte[7:0], last_in_run, text_done
//
// One character is taken per cycle while the group queue is not full; each yields
// a group of 0 to 3 bytes. The serializer sends one byte per cycle while out_chan
// is ready, so a full quartet holds the output for 3 bytes; characters keep flowing
// until the QueueDepth-entry group queue fills. Bytes pass the queue, then the output register.
// Reset (rst_n low, synchronous) clears the quartet state, queue and output.
module base64_stream_decoder_core #(
  parameter int QueueDepth = b64d_pkg::QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  b64d_in_if.sink     in_chan,
  b64d_out_if.source  out_chan
);
  import b64d_pkg::*;

  logic      push;
  b64d_grp_t push_grp;
  logic      q_full;
  logic      pop;
  logic      head_valid;
  b64d_grp_t head_grp;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (push),
    .push_grp (push_grp)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_grp   (push_grp),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_grp   (head_grp)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_grp   (head_grp),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

// ----- dv/tb_top.sv -----
// Testbench for base64_stream_decoder_core: random and directed text with a self-checking scoreboard.
module tb_top;
  import b64d_pkg::*;

  class b64_scoreboard;
    typedef struct packed {
      logic [ByteW-1:0] data;
      logic             last;
      logic             done;
    } dec_byte_t;

    logic [AccW-1:0]  acc;
    logic [HeldW-1:0] held;
    logic [PadW-1:0]  pads;
    dec_byte_t        bytes_q[$];
    int               errors;

    function new();
      acc = '0;
      held = '0;
      pads = '0;
      errors = 0;
    endfunction

    function logic [SymW-1:0] char_to_sym(input logic [CharW-1:0] ch);
      logic [SymW-1:0] s;
      s = SymSkip;
      if (ch >= "A" && ch <= "Z") begin
        s = SymW'(ch - "A");
      end else if (ch >= "a" && ch <= "z") begin
        s = SymW'(ch - "a" + 26);
      end else if (ch >= "0" && ch <= "9") begin
        s = SymW'(ch - "0" + 52);
      end else if (ch == "+" || ch == "-") begin
        s = 7'd62;
      end else if (ch == "/" || ch == "_") begin
        s = 7'd63;
      end else if (ch == "=") begin
        s = SymPad;
      end
      return s;
    endfunction

    function int emit_group(input logic [AccW-1:0] bits, input int npads, input logic eot);
      int count;
      dec_byte_t b;
      count = (npads >= 3) ? 0 : 3 - npads;
      for (int k = 0; k < count; k++) begin
        b.data = bits[16 - 8 * k +: 8];
        b.last = (k == count - 1);
        b.done = eot && (k == count - 1);
        bytes_q.push_back(b);
      end
      acc = '0;
      held = '0;
      pads = '0;
      return count;
    endfunction

    function void note_char(input logic [CharW-1:0] ch, input logic eot);
      logic [SymW-1:0] sym;
      int missing;
      int n;
      sym = char_to_sym(ch);
      if (sym != SymSkip) begin
        acc = {acc[AccW-7:0], (sym == SymPad) ? 6'd0 : sym[5:0]};
        if (sym == SymPad) pads = pads + 1'b1;
        if (held == 2'd3) n = emit_group(acc, pads, eot);
        else held = held + 1'b1;
      end
      if (eot && held != 0) begin
        missing = 4 - held;
        n = emit_group(acc << (6 * missing), pads + missing, eot);
      end
    endfunction

    function void check_byte(input logic [ByteW-1:0] data, input logic last,
                             input logic done);
      dec_byte_t b;
      if (bytes_q.size() == 0) begin
        $error("unexpected byte: out_byte=%h last_in_run=%b text_done=%b", data, last, done);
        errors++;
        return;
      end
      b = bytes_q.pop_front();
      if (data !== b.data) begin
        $error("out_byte: expected %h, actual %h", b.data, data);
        errors++;
      end
      if (last !== b.last) begin
        $error("last_in_run: expected %b, actual %b", b.last, last);
        errors++;
      end
      if (done !== b.done) begin
        $error("text_done: expected %b, actual %b", b.done, done);
        errors++;
      end
    endfunction

    function int pending();
      return bytes_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  b64d_in_if  in_if();
  b64d_out_if out_if();

  base64_stream_decoder_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  b64_scoreboard sb = new();
  int  sent = 0;
  bit  calm = 1'b0;
  bit  hold_off = 1'b0;
  int  stall_left = 0;

  always #5 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.char_code = '0;
    in_if.end_of_text = 1'b0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_byte(out_if.out_byte, out_if.last_in_run, out_if.text_done);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (hold_off) begin
      hold_off = 1'b0;
      stall_left = 79;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_char(input logic [CharW-1:0] ch, input logic eot);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.char_code <= ch;
    in_if.end_of_text <= eot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_char(ch, eot);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [CharW-1:0] symbol_char();
    int v;
    v = $urandom_range(0, 63);
    if (v < 26) return CharW'("A" + v);
    if (v < 52) return CharW'("a" + v - 26);
    if (v < 62) return CharW'("0" + v - 52);
    if (v == 62) return $urandom_range(0, 1) ? ChPlus : ChMinus;
    return $urandom_range(0, 1) ? ChSlash : ChUnder;
  endfunction

  task automatic send_clean_text();
    int quartets;
    int npads;
    int total;
    bit mark_end;
    quartets = $urandom_range(1, 4);
    npads = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
    total = 4 * quartets;
    mark_end = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 9) == 0) send_char(CharW'($urandom_range(0, 255)), 1'b0);
      send_char((i >= total - npads) ? ChEq : symbol_char(), mark_end && (i == total - 1));
    end
  endtask

  task automatic send_broken_text();
    int len;
    int r;
    logic [CharW-1:0] ch;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6) ch = symbol_char();
      else if (r < 8) ch = ChEq;
      else ch = CharW'($urandom_range(0, 255));
      send_char(ch, (i == len - 1) || ($urandom_range(0, 9) == 0));
    end
  endtask

  task automatic send_random_until(input int target);
    while (sent < target) begin
      if ($urandom_range(0, 3) != 0) send_clean_text();
      else send_broken_text();
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_char("A", 1'b0);
    send_char("Z", 1'b0);
    send_char("a", 1'b0);
    send_char("z", 1'b1);
    send_char("0", 1'b0);
    send_char("9", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("+", 1'b0);
    send_char("-", 1'b0);
    send_char("/", 1'b0);
    send_char("_", 1'b0);
    send_char("=", 1'b0);
    send_char("z", 1'b0);
    send_char(8'h00, 1'b1);
    send_char("Q", 1'b1);
    send_char("Q", 1'b0);
    send_char("x", 1'b1);
    send_char("=", 1'b0);
    send_char("=", 1'b0);
    send_char("=", 1'b0);
    send_char("A", 1'b0);
    send_char("b", 1'b0);
    send_char("c", 1'b0);
    send_char("d", 1'b0);
    send_char(8'h80, 1'b1);

    send_random_until(120);

    // hold the receiver while requests keep coming
    hold_off = 1'b1;
    while (sent < 170) send_clean_text();
    wait_drained();

    send_random_until(310);
    calm = 1'b1;
    send_random_until(370);

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
